FILE: src/mos6502_memory_operand_execute_unit_assert.svh
// ---------------------------------------------------------------------------
// mos6502 execute unit assertion macros
// concurrent assertion shorthands clocked on clk, disabled in reset
// ---------------------------------------------------------------------------
`ifndef MOS6502_MEMORY_OPERAND_EXECUTE_UNIT_ASSERT_SVH
`define MOS6502_MEMORY_OPERAND_EXECUTE_UNIT_ASSERT_SVH

// same-cycle implication
`define M6502X_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define M6502X_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: src/m6502x_pkg.sv
// ---------------------------------------------------------------------------
// m6502x_pkg
// shared types, widths and cycle tables of the 6502 memory operand execute unit
// ---------------------------------------------------------------------------
package m6502x_pkg;

	localparam int FUNC_W     = 5;
	localparam int IN_DATA_W  = 32;
	localparam int OUT_DATA_W = 64;

	typedef enum logic [FUNC_W-1:0] {
		FUNC_ORA = 5'd0,
		FUNC_AND = 5'd1,
		FUNC_EOR = 5'd2,
		FUNC_ADC = 5'd3,
		FUNC_STA = 5'd4,
		FUNC_LDA = 5'd5,
		FUNC_CMP = 5'd6,
		FUNC_SBC = 5'd7,
		FUNC_ASL = 5'd8,
		FUNC_ROL = 5'd9,
		FUNC_LSR = 5'd10,
		FUNC_ROR = 5'd11,
		FUNC_STX = 5'd12,
		FUNC_LDX = 5'd13,
		FUNC_DEC = 5'd14,
		FUNC_INC = 5'd15,
		FUNC_BIT = 5'd16,
		FUNC_STY = 5'd17,
		FUNC_LDY = 5'd18,
		FUNC_CPY = 5'd19,
		FUNC_CPX = 5'd20,
		FUNC_JMP = 5'd21
	} func_t;

	localparam logic [3:0] JMP_CYCLES = 4'd3;

	// zero marks a mode the operation does not have
	localparam logic [3:0] CYC_ALU    [8] = '{4'd6, 4'd3, 4'd2, 4'd4, 4'd5, 4'd4, 4'd4, 4'd4};
	localparam logic [3:0] CYC_STA    [8] = '{4'd6, 4'd3, 4'd0, 4'd4, 4'd6, 4'd4, 4'd5, 4'd5};
	localparam logic [3:0] CYC_SHIFT  [8] = '{4'd0, 4'd5, 4'd2, 4'd6, 4'd0, 4'd6, 4'd0, 4'd7};
	localparam logic [3:0] CYC_LDXY   [8] = '{4'd2, 4'd3, 4'd0, 4'd4, 4'd0, 4'd4, 4'd0, 4'd4};
	localparam logic [3:0] CYC_STXY   [8] = '{4'd0, 4'd3, 4'd0, 4'd4, 4'd0, 4'd4, 4'd0, 4'd0};
	localparam logic [3:0] CYC_INCDEC [8] = '{4'd0, 4'd5, 4'd0, 4'd6, 4'd0, 4'd6, 4'd0, 4'd7};
	localparam logic [3:0] CYC_BIT    [8] = '{4'd0, 4'd3, 4'd0, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0};
	localparam logic [3:0] CYC_CPXY   [8] = '{4'd2, 4'd3, 4'd0, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0};

	function automatic logic [3:0] base_cycles(input func_t f, input logic [2:0] mode);
		logic [3:0] c;
		c = 4'd0;
		unique case (f)
			FUNC_ORA, FUNC_AND, FUNC_EOR, FUNC_ADC,
			FUNC_LDA, FUNC_CMP, FUNC_SBC:             c = CYC_ALU[mode];
			FUNC_STA:                                 c = CYC_STA[mode];
			FUNC_ASL, FUNC_ROL, FUNC_LSR, FUNC_ROR:   c = CYC_SHIFT[mode];
			FUNC_STX, FUNC_STY:                       c = CYC_STXY[mode];
			FUNC_LDX, FUNC_LDY:                       c = CYC_LDXY[mode];
			FUNC_DEC, FUNC_INC:                       c = CYC_INCDEC[mode];
			FUNC_BIT:                                 c = CYC_BIT[mode];
			FUNC_CPY, FUNC_CPX:                       c = CYC_CPXY[mode];
			FUNC_JMP:                                 c = JMP_CYCLES;
			default:                                  c = 4'd0;
		endcase
		return c;
	endfunction

	// operations whose cost rises by one on a page cross
	function automatic logic charges_page(input func_t f);
		logic p;
		p = 1'b0;
		unique case (f)
			FUNC_ORA, FUNC_AND, FUNC_EOR, FUNC_ADC, FUNC_LDA,
			FUNC_CMP, FUNC_SBC, FUNC_LDX, FUNC_LDY:   p = 1'b1;
			default:                                  p = 1'b0;
		endcase
		return p;
	endfunction

endpackage

FILE: src/mos6502_memory_operand_execute_unit.sv
// ---------------------------------------------------------------------------
// mos6502_memory_operand_execute_unit
// executes one 6502 memory operand instruction per transaction, binary alu only
//
//   channel   dir  handshake          payload
//   s_*       in   s_tvalid/s_tready  tuser func, tdata mode..on_accumulator
//   m_*       out  m_tvalid/m_tready  tdata acc..bad_mode
//
// one transaction per cycle sustained while m_tready stays high; the result passes
// through the input register and then the result register around the alu
// a, x, y and flags are updated as the transaction leaves the input register
// reset clears a, x, y, the flags and both valid bits
// a stalled result holds; the input register still fills behind it
// ---------------------------------------------------------------------------
module mos6502_memory_operand_execute_unit (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// mode[2:0], address[18:3], read_data[26:19], crossing[27],
	// on_accumulator[28], zero fill
	input  logic [m6502x_pkg::IN_DATA_W-1:0]      s_tdata,
	// func[4:0]
	input  logic [m6502x_pkg::FUNC_W-1:0]         s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// acc[7:0], x_value[15:8], y_value[23:16], flags[27:24], write_enable[28],
	// write_data[36:29], pc_load[37], new_pc[53:38], cycle_cost[57:54],
	// bad_mode[58], zero fill
	output logic [m6502x_pkg::OUT_DATA_W-1:0]     m_tdata
);

	logic                      valid_s1;
	m6502x_pkg::func_t         func_s1;
	logic [2:0]                mode_s1;
	logic [15:0]               address_s1;
	logic [7:0]                read_data_s1;
	logic                      crossing_s1;
	logic                      on_accumulator_s1;

	logic                      valid_s2;
	logic [58:0]               res_s2;

	logic [7:0]                acc_q, x_q, y_q;
	logic                      c_q, z_q, n_q, v_q;

	logic                      advance;
	logic                      fire;

	logic [3:0]                cost;
	logic                      bad;
	logic [3:0]                cost_out;
	logic [7:0]                acc_d, x_d, y_d;
	logic                      c_d, z_d, n_d, v_d;
	logic                      we, pl;
	logic [7:0]                wd;
	logic [15:0]               npc;
	logic [7:0]                operand;
	logic [8:0]                sum;
	logic [7:0]                cmp_reg;
	logic [8:0]                diff;
	logic [7:0]                shift_src;
	logic [7:0]                shift_res;
	logic [7:0]                mem_res;

	assign advance  = !valid_s2 || m_tready;
	assign fire     = valid_s1 && advance;
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			func_s1           <= m6502x_pkg::func_t'(s_tuser);
			mode_s1           <= s_tdata[2:0];
			address_s1        <= s_tdata[18:3];
			read_data_s1      <= s_tdata[26:19];
			crossing_s1       <= s_tdata[27];
			on_accumulator_s1 <= s_tdata[28];
		end
	end

	always_comb begin
		cost      = m6502x_pkg::base_cycles(func_s1, mode_s1);
		bad       = (cost == 4'd0);
		cost_out  = bad ? 4'd0 :
			cost + {3'd0, crossing_s1 && m6502x_pkg::charges_page(func_s1)};

		operand   = (func_s1 == m6502x_pkg::FUNC_SBC) ? ~read_data_s1 : read_data_s1;
		sum       = {1'b0, acc_q} + {1'b0, operand} + {8'd0, c_q};
		unique case (func_s1)
			m6502x_pkg::FUNC_CPX: cmp_reg = x_q;
			m6502x_pkg::FUNC_CPY: cmp_reg = y_q;
			default:              cmp_reg = acc_q;
		endcase
		diff      = {1'b0, cmp_reg} - {1'b0, read_data_s1};
		shift_src = on_accumulator_s1 ? acc_q : read_data_s1;
		unique case (func_s1)
			m6502x_pkg::FUNC_ASL: shift_res = {shift_src[6:0], 1'b0};
			m6502x_pkg::FUNC_ROL: shift_res = {shift_src[6:0], c_q};
			m6502x_pkg::FUNC_LSR: shift_res = {1'b0, shift_src[7:1]};
			default:              shift_res = {c_q, shift_src[7:1]};
		endcase
		mem_res   = (func_s1 == m6502x_pkg::FUNC_DEC) ? read_data_s1 - 8'd1 :
			read_data_s1 + 8'd1;

		acc_d = acc_q;
		x_d   = x_q;
		y_d   = y_q;
		c_d   = c_q;
		z_d   = z_q;
		n_d   = n_q;
		v_d   = v_q;
		we    = 1'b0;
		wd    = 8'd0;
		pl    = 1'b0;
		npc   = 16'd0;

		if (!bad) begin
			unique case (func_s1)
				m6502x_pkg::FUNC_ORA, m6502x_pkg::FUNC_AND, m6502x_pkg::FUNC_EOR,
				m6502x_pkg::FUNC_LDA: begin
					if (func_s1 == m6502x_pkg::FUNC_ORA)
						acc_d = acc_q | read_data_s1;
					else if (func_s1 == m6502x_pkg::FUNC_AND)
						acc_d = acc_q & read_data_s1;
					else if (func_s1 == m6502x_pkg::FUNC_EOR)
						acc_d = acc_q ^ read_data_s1;
					else
						acc_d = read_data_s1;
					z_d = (acc_d == 8'd0);
					n_d = acc_d[7];
				end
				m6502x_pkg::FUNC_ADC, m6502x_pkg::FUNC_SBC: begin
					acc_d = sum[7:0];
					c_d   = sum[8];
					v_d   = ~(acc_q[7] ^ operand[7]) & (acc_q[7] ^ sum[7]);
					z_d   = (sum[7:0] == 8'd0);
					n_d   = sum[7];
				end
				m6502x_pkg::FUNC_CMP, m6502x_pkg::FUNC_CPX, m6502x_pkg::FUNC_CPY: begin
					c_d = !diff[8];
					z_d = (diff[7:0] == 8'd0);
					n_d = diff[7];
				end
				m6502x_pkg::FUNC_STA: begin
					we = 1'b1;
					wd = acc_q;
				end
				m6502x_pkg::FUNC_STX: begin
					we = 1'b1;
					wd = x_q;
				end
				m6502x_pkg::FUNC_STY: begin
					we = 1'b1;
					wd = y_q;
				end
				m6502x_pkg::FUNC_ASL, m6502x_pkg::FUNC_ROL,
				m6502x_pkg::FUNC_LSR, m6502x_pkg::FUNC_ROR: begin
					if (func_s1 == m6502x_pkg::FUNC_ASL || func_s1 == m6502x_pkg::FUNC_ROL)
						c_d = shift_src[7];
					else
						c_d = shift_src[0];
					z_d = (shift_res == 8'd0);
					n_d = shift_res[7];
					if (on_accumulator_s1) begin
						acc_d = shift_res;
					end else begin
						we = 1'b1;
						wd = shift_res;
					end
				end
				m6502x_pkg::FUNC_LDX: begin
					x_d = read_data_s1;
					z_d = (read_data_s1 == 8'd0);
					n_d = read_data_s1[7];
				end
				m6502x_pkg::FUNC_LDY: begin
					y_d = read_data_s1;
					z_d = (read_data_s1 == 8'd0);
					n_d = read_data_s1[7];
				end
				m6502x_pkg::FUNC_DEC, m6502x_pkg::FUNC_INC: begin
					we  = 1'b1;
					wd  = mem_res;
					z_d = (mem_res == 8'd0);
					n_d = mem_res[7];
				end
				m6502x_pkg::FUNC_BIT: begin
					z_d = ((acc_q & read_data_s1) == 8'd0);
					n_d = read_data_s1[7];
					v_d = read_data_s1[6];
				end
				m6502x_pkg::FUNC_JMP: begin
					pl  = 1'b1;
					npc = address_s1;
				end
				default: begin
					pl = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= 8'd0;
			x_q   <= 8'd0;
			y_q   <= 8'd0;
			c_q   <= 1'b0;
			z_q   <= 1'b0;
			n_q   <= 1'b0;
			v_q   <= 1'b0;
		end else if (fire) begin
			acc_q <= acc_d;
			x_q   <= x_d;
			y_q   <= y_d;
			c_q   <= c_d;
			z_q   <= z_d;
			n_q   <= n_d;
			v_q   <= v_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			res_s2 <= {bad, cost_out, npc, pl, wd, we,
				n_d, v_d, z_d, c_d, y_d, x_d, acc_d};
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = {{(m6502x_pkg::OUT_DATA_W - 59){1'b0}}, res_s2};

endmodule

FILE: src/m6502x_checker.sv
// ---------------------------------------------------------------------------
// m6502x_checker
// port level checks of the 6502 memory operand execute unit, bound to the top
// ---------------------------------------------------------------------------
`include "mos6502_memory_operand_execute_unit_assert.svh"

module m6502x_checker (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tready,
	input  logic                                  m_tvalid,
	input  logic                                  m_tready,
	input  logic [m6502x_pkg::OUT_DATA_W-1:0]     m_tdata
);

	logic        bad_mode;
	logic        write_enable;
	logic        pc_load;
	logic [7:0]  write_data;
	logic [15:0] new_pc;
	logic [3:0]  cycle_cost;

	assign write_enable = m_tdata[28];
	assign write_data   = m_tdata[36:29];
	assign pc_load      = m_tdata[37];
	assign new_pc       = m_tdata[53:38];
	assign cycle_cost   = m_tdata[57:54];
	assign bad_mode     = m_tdata[58];

	`M6502X_ASSERT_NOW(a_bad_is_inert, m_tvalid && bad_mode,
		cycle_cost == 4'd0 && !write_enable && !pc_load, "bad mode result has side effects")

	`M6502X_ASSERT_NOW(a_side_data_zero, m_tvalid,
		(write_enable || write_data == 8'd0) && (pc_load || new_pc == 16'd0),
		"write data or jump target set without its enable")

	`M6502X_ASSERT_NOW(a_jmp_cost, m_tvalid && pc_load,
		cycle_cost == m6502x_pkg::JMP_CYCLES && !write_enable && !bad_mode,
		"jump result with wrong cost or a memory write")

	`M6502X_ASSERT_NEXT(a_stall_hold, m_tvalid && !m_tready,
		m_tvalid && $stable(m_tdata), "stalled result changed")

	`M6502X_ASSERT_NOW(a_ready_when_empty, !m_tvalid,
		s_tready, "input not ready while the output is empty")

endmodule

bind mos6502_memory_operand_execute_unit m6502x_checker u_m6502x_checker (.*);

FILE: dv/tb.sv
// ---------------------------------------------------------------------------
// tb
// self-checking bench for the 6502 memory operand execute unit: an in-bench
// model of A, X, Y and the flags predicts every result, a monitor compares
// each result field by field; directed corner cases, then random traffic
// with random idling on both sides and three full drains of the pipeline
// ---------------------------------------------------------------------------
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	// addressing mode field, group one meaning
	localparam logic [2:0] MODE_IND_X  = 3'd0;
	localparam logic [2:0] MODE_ZP     = 3'd1;
	localparam logic [2:0] MODE_IMM    = 3'd2;
	localparam logic [2:0] MODE_ABS    = 3'd3;
	localparam logic [2:0] MODE_IND_Y  = 3'd4;
	localparam logic [2:0] MODE_ZP_X   = 3'd5;
	localparam logic [2:0] MODE_ABS_Y  = 3'd6;
	localparam logic [2:0] MODE_ABS_X  = 3'd7;
	// immediate for the x/y group
	localparam logic [2:0] MODE_IMM_XY = 3'd0;

	// cycle rows, one nibble per mode, mode 0 lowest, zero for no such mode
	localparam logic [31:0] ALU_ROW    = 32'h4445_4236;
	localparam logic [31:0] STA_ROW    = 32'h5546_4036;
	localparam logic [31:0] SHIFT_ROW  = 32'h7060_6250;
	localparam logic [31:0] LDXY_ROW   = 32'h4040_4032;
	localparam logic [31:0] STXY_ROW   = 32'h0040_4030;
	localparam logic [31:0] INCDEC_ROW = 32'h7060_6050;
	localparam logic [31:0] BIT_ROW    = 32'h0000_4030;
	localparam logic [31:0] CPXY_ROW   = 32'h0000_4032;
	localparam logic [31:0] JMP_ROW    = 32'h3333_3333;

	localparam int RANDOM_ITEMS = 450;
	localparam int DRAIN_EVERY  = 150;
	// quiet stretch limit, well beyond the longest driver idling plus monitor stall and pipeline latency
	localparam int IDLE_LIMIT   = 400;

	typedef struct packed {
		logic [2:0]  pad;
		logic        on_acc;
		logic        crossing;
		logic [7:0]  data;
		logic [15:0] address;
		logic [2:0]  mode;
	} operand_t;

	typedef struct {
		logic [m6502x_pkg::FUNC_W-1:0] op;
		operand_t                      opnd;
		bit                            drain;
	} instr_t;

	typedef struct packed {
		logic [4:0]  pad;
		logic        bad;
		logic [3:0]  cost;
		logic [15:0] npc;
		logic        pl;
		logic [7:0]  wd;
		logic        we;
		logic [3:0]  flags;
		logic [7:0]  y;
		logic [7:0]  x;
		logic [7:0]  a;
	} result_t;

	logic                              clk      = 1'b0;
	logic                              arst_n   = 1'b0;
	logic                              s_tvalid = 1'b0;
	logic                              s_tready;
	logic [m6502x_pkg::IN_DATA_W-1:0]  s_tdata  = '0;
	logic [m6502x_pkg::FUNC_W-1:0]     s_tuser  = '0;
	logic                              m_tvalid;
	logic                              m_tready = 1'b0;
	logic [m6502x_pkg::OUT_DATA_W-1:0] m_tdata;

	// architectural state of the model
	logic [7:0] reg_a = '0, reg_x = '0, reg_y = '0;
	logic       flag_c = 1'b0, flag_z = 1'b0, flag_n = 1'b0, flag_v = 1'b0;

	instr_t  pending_instrs[$];
	result_t exec_results[$];

	int errors      = 0;
	int n_sent      = 0;
	int n_directed  = 0;
	int n_results   = 0;
	int n_writes    = 0;
	int n_jumps     = 0;
	int n_bad       = 0;
	int cycle_count = 0;

	mos6502_memory_operand_execute_unit dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	always #6 clk = ~clk;

	function automatic void set_nz(input logic [7:0] v);
		flag_z = (v == 8'h00);
		flag_n = v[7];
	endfunction

	function automatic void add_carry(input logic [7:0] m);
		logic [8:0] sum;
		sum = {1'b0, reg_a} + {1'b0, m} + {8'h00, flag_c};
		flag_c = sum[8];
		flag_v = ~(reg_a[7] ^ m[7]) & (reg_a[7] ^ sum[7]);
		reg_a = sum[7:0];
		set_nz(sum[7:0]);
	endfunction

	function automatic void compare_reg(input logic [7:0] r, input logic [7:0] m);
		flag_c = (r >= m);
		set_nz(r - m);
	endfunction

	function automatic result_t execute(input instr_t ins);
		result_t     r;
		logic [31:0] row;
		logic [3:0]  cost;
		logic [7:0]  m, src, v;
		logic        cin, paid;
		r = '0;
		m = ins.opnd.data;
		paid = 1'b0;
		case (ins.op)
			m6502x_pkg::FUNC_ORA, m6502x_pkg::FUNC_AND, m6502x_pkg::FUNC_EOR,
			m6502x_pkg::FUNC_ADC, m6502x_pkg::FUNC_LDA, m6502x_pkg::FUNC_CMP,
			m6502x_pkg::FUNC_SBC:                           row = ALU_ROW;
			m6502x_pkg::FUNC_STA:                           row = STA_ROW;
			m6502x_pkg::FUNC_ASL, m6502x_pkg::FUNC_ROL,
			m6502x_pkg::FUNC_LSR, m6502x_pkg::FUNC_ROR:     row = SHIFT_ROW;
			m6502x_pkg::FUNC_STX, m6502x_pkg::FUNC_STY:     row = STXY_ROW;
			m6502x_pkg::FUNC_LDX, m6502x_pkg::FUNC_LDY:     row = LDXY_ROW;
			m6502x_pkg::FUNC_DEC, m6502x_pkg::FUNC_INC:     row = INCDEC_ROW;
			m6502x_pkg::FUNC_BIT:                           row = BIT_ROW;
			m6502x_pkg::FUNC_CPX, m6502x_pkg::FUNC_CPY:     row = CPXY_ROW;
			m6502x_pkg::FUNC_JMP:                           row = JMP_ROW;
			default:                                        row = '0;
		endcase
		cost = row[ins.opnd.mode*4 +: 4];
		if (cost == 4'd0) begin
			r.bad = 1'b1;
		end else begin
			case (ins.op)
				m6502x_pkg::FUNC_ORA: begin
					reg_a = reg_a | m; set_nz(reg_a); paid = 1'b1;
				end
				m6502x_pkg::FUNC_AND: begin
					reg_a = reg_a & m; set_nz(reg_a); paid = 1'b1;
				end
				m6502x_pkg::FUNC_EOR: begin
					reg_a = reg_a ^ m; set_nz(reg_a); paid = 1'b1;
				end
				m6502x_pkg::FUNC_ADC: begin
					add_carry(m); paid = 1'b1;
				end
				m6502x_pkg::FUNC_SBC: begin
					add_carry(~m); paid = 1'b1;
				end
				m6502x_pkg::FUNC_LDA: begin
					reg_a = m; set_nz(m); paid = 1'b1;
				end
				m6502x_pkg::FUNC_CMP: begin
					compare_reg(reg_a, m); paid = 1'b1;
				end
				m6502x_pkg::FUNC_STA: begin
					r.we = 1'b1; r.wd = reg_a;
				end
				m6502x_pkg::FUNC_ASL, m6502x_pkg::FUNC_ROL,
				m6502x_pkg::FUNC_LSR, m6502x_pkg::FUNC_ROR: begin
					src = ins.opnd.on_acc ? reg_a : m;
					cin = flag_c;
					if (ins.op == m6502x_pkg::FUNC_ASL || ins.op == m6502x_pkg::FUNC_ROL) begin
						flag_c = src[7];
						v = {src[6:0], (ins.op == m6502x_pkg::FUNC_ROL) & cin};
					end else begin
						flag_c = src[0];
						v = {(ins.op == m6502x_pkg::FUNC_ROR) & cin, src[7:1]};
					end
					set_nz(v);
					if (ins.opnd.on_acc) begin
						reg_a = v;
					end else begin
						r.we = 1'b1; r.wd = v;
					end
				end
				m6502x_pkg::FUNC_STX: begin
					r.we = 1'b1; r.wd = reg_x;
				end
				m6502x_pkg::FUNC_STY: begin
					r.we = 1'b1; r.wd = reg_y;
				end
				m6502x_pkg::FUNC_LDX: begin
					reg_x = m; set_nz(m); paid = 1'b1;
				end
				m6502x_pkg::FUNC_LDY: begin
					reg_y = m; set_nz(m); paid = 1'b1;
				end
				m6502x_pkg::FUNC_DEC: begin
					r.we = 1'b1; r.wd = m - 8'd1; set_nz(r.wd);
				end
				m6502x_pkg::FUNC_INC: begin
					r.we = 1'b1; r.wd = m + 8'd1; set_nz(r.wd);
				end
				m6502x_pkg::FUNC_BIT: begin
					flag_z = ((reg_a & m) == 8'h00);
					flag_n = m[7];
					flag_v = m[6];
				end
				m6502x_pkg::FUNC_CPX: compare_reg(reg_x, m);
				m6502x_pkg::FUNC_CPY: compare_reg(reg_y, m);
				m6502x_pkg::FUNC_JMP: begin
					r.pl = 1'b1; r.npc = ins.opnd.address;
				end
				default: ;
			endcase
			r.cost = cost + {3'b000, paid & ins.opnd.crossing};
		end
		r.a = reg_a;
		r.x = reg_x;
		r.y = reg_y;
		r.flags = {flag_n, flag_v, flag_z, flag_c};
		return r;
	endfunction

	function automatic int draw_wait();
		// every fourth stretch of the run has no idling at all
		return ((cycle_count % 800) >= 600) ? 0 : int'($urandom_range(0, 11));
	endfunction

	task automatic report(input string what);
		errors++;
		if (errors <= 20)
			$display("error at %0t ns: %s", $realtime, what);
	endtask

	task automatic check_field(input string name, input int got, input int want);
		if (got != want)
			report($sformatf("result %0d field %s: got 0x%0h, expected 0x%0h",
				n_results, name, got, want));
	endtask

	task automatic queue_instr(input logic [m6502x_pkg::FUNC_W-1:0] op,
			input logic [2:0] mode, input logic [15:0] addr, input logic [7:0] data,
			input logic pc, input logic on_acc, input bit drain);
		instr_t ins;
		ins.op = op;
		ins.opnd = '{pad: 3'b000, on_acc: on_acc, crossing: pc, data: data,
			address: addr, mode: mode};
		ins.drain = drain;
		pending_instrs.push_back(ins);
	endtask

	// driver
	always @(posedge clk) begin : driver
		instr_t cur;
		logic   busy;
		int     gap;
		if (arst_n) begin
			busy = s_tvalid;
			if (s_tvalid && s_tready) begin
				exec_results.push_back(execute(cur));
				n_sent++;
				busy = 1'b0;
			end
			if (!busy) begin
				if (gap > 0) begin
					gap--;
				end else if (pending_instrs.size() != 0 &&
						!(pending_instrs[0].drain && exec_results.size() != 0)) begin
					cur = pending_instrs.pop_front();
					s_tdata <= cur.opnd;
					s_tuser <= cur.op;
					busy = 1'b1;
					gap = draw_wait();
				end
			end
			s_tvalid <= busy;
		end
	end

	// monitor
	always @(posedge clk) begin : monitor
		result_t seen, want;
		int      stall;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				seen = m_tdata;
				n_results++;
				if (seen.we) n_writes++;
				if (seen.pl) n_jumps++;
				if (seen.bad) n_bad++;
				if (exec_results.size() == 0) begin
					report($sformatf("result 0x%0h with no instruction outstanding", m_tdata));
				end else begin
					want = exec_results.pop_front();
					check_field("acc", int'(seen.a), int'(want.a));
					check_field("x_value", int'(seen.x), int'(want.x));
					check_field("y_value", int'(seen.y), int'(want.y));
					check_field("flags", int'(seen.flags), int'(want.flags));
					check_field("write_enable", int'(seen.we), int'(want.we));
					check_field("write_data", int'(seen.wd), int'(want.wd));
					check_field("pc_load", int'(seen.pl), int'(want.pl));
					check_field("new_pc", int'(seen.npc), int'(want.npc));
					check_field("cycle_cost", int'(seen.cost), int'(want.cost));
					check_field("bad_mode", int'(seen.bad), int'(want.bad));
				end
				stall = draw_wait();
			end
			if (stall > 0) begin
				stall--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// watchdog
	always @(posedge clk) begin : watchdog
		int idle;
		cycle_count++;
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle = 0;
			else
				idle++;
			if (idle >= IDLE_LIMIT) begin
				$display("timeout: no transaction in %0d cycles", IDLE_LIMIT);
				$display("tb failed");
				$finish;
			end
		end
	end

	initial begin : stimulus
		logic [m6502x_pkg::FUNC_W-1:0] op;
		logic [7:0]                    data;
		int                            i;

		// directed corners: every operation, extreme operands, flag edge cases
		queue_instr(m6502x_pkg::FUNC_LDA, MODE_IMM,    16'h0000, 8'h80, 1'b0, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_ADC, MODE_IMM,    16'hFFFF, 8'h80, 1'b1, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_SBC, MODE_ABS_X,  16'h1234, 8'h00, 1'b1, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_ORA, MODE_ZP,     16'h00FF, 8'hFF, 1'b0, 1'b1, 0);
		queue_instr(m6502x_pkg::FUNC_AND, MODE_IND_Y,  16'hFF00, 8'h7F, 1'b1, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_EOR, MODE_IND_X,  16'h8000, 8'hFF, 1'b0, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_CMP, MODE_IMM,    16'h0001, 8'h7F, 1'b1, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_STA, MODE_ZP_X,   16'h0100, 8'h55, 1'b1, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_STA, MODE_ABS_Y,  16'h0300, 8'h00, 1'b1, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_LDX, MODE_IMM_XY, 16'hFFFF, 8'hFF, 1'b1, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_LDY, MODE_ABS,    16'h0000, 8'h00, 1'b1, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_CPX, MODE_ZP,     16'h1000, 8'hFF, 1'b1, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_CPY, MODE_IMM_XY, 16'h2000, 8'h00, 1'b0, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_STX, MODE_ZP,     16'h00AA, 8'h00, 1'b1, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_STY, MODE_ABS,    16'hAAAA, 8'hFF, 1'b0, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_ASL, MODE_IMM,    16'h5555, 8'h01, 1'b0, 1'b1, 0);
		queue_instr(m6502x_pkg::FUNC_ROL, MODE_ZP,     16'h0080, 8'h80, 1'b1, 1'b0, 0);
		// shift on the accumulator while the mode names memory
		queue_instr(m6502x_pkg::FUNC_LSR, MODE_ABS,    16'h4000, 8'hFF, 1'b0, 1'b1, 0);
		queue_instr(m6502x_pkg::FUNC_ROR, MODE_ABS_X,  16'hFFFE, 8'h01, 1'b0, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_INC, MODE_ZP,     16'h00FE, 8'hFF, 1'b1, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_DEC, MODE_ABS,    16'h7FFF, 8'h00, 1'b0, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_BIT, MODE_ZP,     16'h0040, 8'hC0, 1'b0, 1'b0, 0);
		queue_instr(m6502x_pkg::FUNC_BIT, MODE_ABS,    16'h3F3F, 8'h3F, 1'b1, 1'b0, 0);
		// jump under an unusual mode still carries the JMP_CYCLES cost
		queue_instr(m6502x_pkg::FUNC_JMP, MODE_IND_Y,  16'hFFFF, 8'h12, 1'b1, 1'b1, 0);
		queue_instr(m6502x_pkg::FUNC_STA, MODE_IMM,    16'h0200, 8'h34, 1'b1, 1'b0, 0);
		queue_instr(5'((1 << m6502x_pkg::FUNC_W) - 1), MODE_ABS, 16'hC000, 8'h80,
			1'b1, 1'b1, 0);
		n_directed = pending_instrs.size();

		for (i = 0; i < RANDOM_ITEMS; i++) begin
			if ($urandom_range(0, 24) == 0)
				op = 5'($urandom_range(m6502x_pkg::FUNC_JMP + 1,
					(1 << m6502x_pkg::FUNC_W) - 1));
			else
				op = 5'($urandom_range(0, m6502x_pkg::FUNC_JMP));
			case ($urandom_range(0, 5))
				0:       data = 8'h00;
				1:       data = 8'hFF;
				2:       data = 8'h80;
				3:       data = 8'h7F;
				default: data = 8'($urandom);
			endcase
			queue_instr(op, 3'($urandom_range(0, 7)), 16'($urandom), data,
				1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
				(i % DRAIN_EVERY) == 0);
		end

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		while (pending_instrs.size() != 0 || s_tvalid || exec_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);

		$display("covered %0d instructions (%0d directed), %0d results checked",
			n_sent, n_directed, n_results);
		$display("results: %0d memory writes, %0d jumps, %0d invalid modes, %0d errors",
			n_writes, n_jumps, n_bad, errors);
		if (errors == 0) begin
			$display("tb passed");
		end else begin
			$display("tb failed");
		end
		$finish;
	end

endmodule
